// ===== design/coalesced_hash_table_assert.svh =====
// Assertion macros used by the hash table sequencer RTL.
`ifndef COALESCED_HASH_TABLE_ASSERT_SVH
`define COALESCED_HASH_TABLE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define CHT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define CHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cht_pkg.sv =====
package cht_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int KEY_W = 31;
   localparam int BITCNT_W = $clog2(KEY_W);
   localparam int SLOT_FIELD_W = 4;
   localparam bit SLOTS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

   localparam logic [SLOT_W:0] SLOT_CNT = (SLOT_W + 1)'(TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
   localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(KEY_W - 1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_HEAD,
      S_TAIL,
      S_FREE,
      S_WALK,
      S_WNEW,
      S_WLINK,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] home;
      logic [KEY_W-1:0]  key;
   } key_entry_type;

   typedef struct packed {
      logic              has_next;
      logic [SLOT_W-1:0] next_slot;
   } link_entry_type;

   typedef struct packed {
      logic [SLOT_W-1:0] rd_addr;
      logic              key_we;
      logic [SLOT_W-1:0] key_waddr;
      key_entry_type     key_wdata;
      logic              link_we;
      logic [SLOT_W-1:0] link_waddr;
      link_entry_type    link_wdata;
   } mem_ctrl_type;

   typedef struct packed {
      logic                    valid;
      status_type              status;
      logic [SLOT_FIELD_W-1:0] slot;
   } result_type;

   function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] a);
      return (a == LAST_SLOT) ? '0 : a + SLOT_W'(1);
   endfunction

   function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] a);
      logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
      wide = {{SLOT_FIELD_W{1'b0}}, a};
      return wide[SLOT_FIELD_W-1:0];
   endfunction

endpackage

// ===== design/coalesced_hash_table.sv =====
// Hash table with coalesced chains (chaining without replacement) over
// linear probing. The request channel carries req_command (insert or
// search) and req_key_value; each request beat yields exactly one response
// beat with rsp_status and rsp_slot. Both channels use valid and stall.
// After reset the block sweeps the table once to clear the valid marks and
// links, one slot a cycle, and stalls requests until the sweep is done.
// A request is then handled by one sequencer over a table with one read
// address and a registered read: one slot is examined per cycle while
// probing for the chain head, walking the chain and probing for a free
// slot. The next request can be accepted at the edge of the response
// beat. When the table size is not a power of two, the home slot is
// first computed one key bit at a time.
// Requests are stalled while one is in progress. The response sits in an
// output register; a stalled response holds, and a finished result waits
// in the sequencer, with requests still stalled, until the register frees.
module coalesced_hash_table import cht_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_command,
   input  logic [KEY_W-1:0]        req_key_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [SLOT_FIELD_W-1:0] rsp_slot
);

   mem_ctrl_type            ctrl;
   key_entry_type           key_rd;
   link_entry_type          link_rd;
   result_type              result;
   logic                    busy;
   logic                    out_free;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy;

   cht_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid && !busy),
      .command   (req_command),
      .key_value (req_key_value),
      .out_free  (out_free),
      .busy      (busy),
      .result    (result),
      .ctrl      (ctrl),
      .key_rd    (key_rd),
      .link_rd   (link_rd)
   );

   cht_store u_store (
      .clock   (clock),
      .ctrl    (ctrl),
      .key_rd  (key_rd),
      .link_rd (link_rd)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in = rsp_slot_ff;
      if (result.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = result.status;
         rsp_slot_in = result.slot;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot = rsp_slot_ff;

endmodule

// ===== design/cht_store.sv =====
module cht_store import cht_pkg::*; (
   input  logic           clock,
   input  mem_ctrl_type   ctrl,
   output key_entry_type  key_rd,
   output link_entry_type link_rd
);

   key_entry_type  key_mem [TABLE_SLOTS];
   link_entry_type link_mem [TABLE_SLOTS];
   key_entry_type  key_rd_ff;
   link_entry_type link_rd_ff;

   always_ff @(posedge clock) begin
      if (ctrl.key_we) begin
         key_mem[ctrl.key_waddr] <= ctrl.key_wdata;
      end
      key_rd_ff <= key_mem[ctrl.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.link_we) begin
         link_mem[ctrl.link_waddr] <= ctrl.link_wdata;
      end
      link_rd_ff <= link_mem[ctrl.rd_addr];
   end

   assign key_rd = key_rd_ff;
   assign link_rd = link_rd_ff;

endmodule

// ===== design/cht_seq.sv =====
`include "coalesced_hash_table_assert.svh"

module cht_seq import cht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             command,
   input  logic [KEY_W-1:0] key_value,
   input  logic             out_free,
   output logic             busy,
   output result_type       result,
   output mem_ctrl_type     ctrl,
   input  key_entry_type    key_rd,
   input  link_entry_type   link_rd
);

   seq_state_type         state_ff, state_in;
   logic                  cmd_ff, cmd_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [SLOT_W-1:0]     home_ff, home_in;
   logic [SLOT_W-1:0]     addr_ff, addr_in;
   logic [SLOT_W-1:0]     cnt_ff, cnt_in;
   logic [SLOT_W-1:0]     rem_ff, rem_in;
   logic [BITCNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [SLOT_W-1:0]     tail_ff, tail_in;
   logic                  link_ff, link_in;
   status_type            status_ff, status_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SLOT_W:0]       rem_shift;
   logic [SLOT_W:0]       rem_sub;
   logic [SLOT_W-1:0]     rem_next;
   logic                  chain_end;

   assign rem_shift = {rem_ff, key_ff[bit_cnt_ff]};
   assign rem_sub = rem_shift - SLOT_CNT;
   assign rem_next = (rem_shift >= SLOT_CNT) ? rem_sub[SLOT_W-1:0] : rem_shift[SLOT_W-1:0];
   assign chain_end = !link_rd.has_next || ({1'b0, link_rd.next_slot} >= SLOT_CNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      home_ff <= home_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      tail_ff <= tail_in;
      link_ff <= link_in;
      status_ff <= status_in;
      slot_ff <= slot_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      home_in = home_ff;
      addr_in = addr_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      tail_in = tail_ff;
      link_in = link_ff;
      status_in = status_ff;
      slot_in = slot_ff;
      ctrl = '0;
      busy = (state_ff != S_IDLE);
      result.valid = (state_ff == S_DONE);
      result.status = status_ff;
      result.slot = slot_field(slot_ff);

      case (state_ff)
         S_CLEAR: begin
            ctrl.key_we = 1'b1;
            ctrl.key_waddr = addr_ff;
            ctrl.link_we = 1'b1;
            ctrl.link_waddr = addr_ff;
            addr_in = wrap_inc(addr_ff);
            if (addr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in = command;
               key_in = key_value;
               link_in = 1'b0;
               cnt_in = '0;
               rem_in = '0;
               bit_cnt_in = LAST_BIT;
               if (SLOTS_POW2) begin
                  home_in = key_value[SLOT_W-1:0];
                  addr_in = key_value[SLOT_W-1:0];
                  state_in = S_HEAD;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            rem_in = rem_next;
            bit_cnt_in = bit_cnt_ff - BITCNT_W'(1);
            if (bit_cnt_ff == '0) begin
               home_in = rem_next;
               addr_in = rem_next;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (cnt_ff == '0 && cmd_ff == CMD_INSERT && !key_rd.valid) begin
               state_in = S_WNEW;
            end else if (key_rd.valid && key_rd.home == home_ff) begin
               cnt_in = '0;
               if (cmd_ff == CMD_INSERT) begin
                  link_in = 1'b1;
                  state_in = S_TAIL;
               end else begin
                  state_in = S_WALK;
               end
            end else if (cnt_ff == LAST_SLOT) begin
               cnt_in = '0;
               if (cmd_ff == CMD_INSERT) begin
                  addr_in = home_ff;
                  state_in = S_FREE;
               end else begin
                  status_in = ST_NOT_FOUND;
                  slot_in = '0;
                  state_in = S_DONE;
               end
            end else begin
               addr_in = wrap_inc(addr_ff);
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         S_TAIL: begin
            if (chain_end) begin
               tail_in = addr_ff;
               cnt_in = '0;
               state_in = S_FREE;
            end else if (cnt_ff == LAST_SLOT) begin
               tail_in = link_rd.next_slot;
               addr_in = link_rd.next_slot;
               cnt_in = '0;
               state_in = S_FREE;
            end else begin
               addr_in = link_rd.next_slot;
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         S_FREE: begin
            if (!key_rd.valid) begin
               state_in = S_WNEW;
            end else if (cnt_ff == LAST_SLOT) begin
               status_in = ST_FULL;
               slot_in = '0;
               state_in = S_DONE;
            end else begin
               addr_in = wrap_inc(addr_ff);
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         S_WALK: begin
            if (key_rd.valid && key_rd.key == key_ff) begin
               status_in = ST_FOUND;
               slot_in = addr_ff;
               state_in = S_DONE;
            end else if (chain_end || cnt_ff == LAST_SLOT) begin
               status_in = ST_NOT_FOUND;
               slot_in = '0;
               state_in = S_DONE;
            end else begin
               addr_in = link_rd.next_slot;
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         S_WNEW: begin
            ctrl.key_we = 1'b1;
            ctrl.key_waddr = addr_ff;
            ctrl.key_wdata.valid = 1'b1;
            ctrl.key_wdata.home = home_ff;
            ctrl.key_wdata.key = key_ff;
            ctrl.link_we = 1'b1;
            ctrl.link_waddr = addr_ff;
            slot_in = addr_ff;
            status_in = ST_INSERTED;
            state_in = link_ff ? S_WLINK : S_DONE;
         end
         S_WLINK: begin
            ctrl.link_we = 1'b1;
            ctrl.link_waddr = tail_ff;
            ctrl.link_wdata.has_next = 1'b1;
            ctrl.link_wdata.next_slot = slot_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      ctrl.rd_addr = addr_in;
   end

   `CHT_ASSERT_IMPLY(a_link_not_self, clock, reset, state_ff == S_WLINK, tail_ff != slot_ff,
      "chain link would point a slot at itself")
   `CHT_ASSERT_NEXT(a_wnew_exit, clock, reset, state_ff == S_WNEW,
      state_ff == S_WLINK || state_ff == S_DONE, "bad exit from key store")
   `CHT_ASSERT_IMPLY(a_store_valid, clock, reset, ctrl.key_we && state_ff != S_CLEAR,
      ctrl.key_wdata.valid, "key stored without its valid mark")
   `CHT_ASSERT_IMPLY(a_free_slot, clock, reset, state_ff == S_WNEW && link_ff,
      $past(state_ff) == S_FREE, "linked insert did not come from a free probe")

endmodule

// ===== tb/cht_checker.sv =====
`default_nettype none

module cht_checker import cht_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_stall,
   input  wire logic                    req_command,
   input  wire logic [KEY_W-1:0]        req_key_value,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire logic [1:0]              rsp_status,
   input  wire logic [SLOT_FIELD_W-1:0] rsp_slot,
   output int                           outstanding,
   output int                           mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type              status;
      logic [SLOT_FIELD_W-1:0] slot;
   } answer_type;

   logic [KEY_W-1:0] held_key [TABLE_SLOTS];
   bit               held     [TABLE_SLOTS];
   int unsigned      link     [TABLE_SLOTS];
   bit               linked   [TABLE_SLOTS];
   answer_type       pending_answers [$];

   function automatic bit chain_head(input int unsigned home, output int unsigned head);
      int unsigned s;
      head = 0;
      for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
         s = (home + i) % TABLE_SLOTS;
         if (held[s] && (held_key[s] % TABLE_SLOTS) == home) begin
            head = s;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void fill_slot(input int unsigned s, input logic [KEY_W-1:0] key);
      held_key[s] = key;
      held[s] = 1'b1;
      linked[s] = 1'b0;
      link[s] = 0;
   endfunction

   function automatic answer_type hash_answer(input logic cmd, input logic [KEY_W-1:0] key);
      int unsigned home;
      int unsigned head;
      int unsigned tail;
      int unsigned spot;
      int unsigned cur;
      bit          has_head;
      bit          has_free;
      answer_type  answer;
      home = key % TABLE_SLOTS;
      answer.status = ST_NOT_FOUND;
      answer.slot = '0;
      if (cmd == CMD_INSERT) begin
         answer.status = ST_FULL;
         if (!held[home]) begin
            fill_slot(home, key);
            answer.status = ST_INSERTED;
            answer.slot = SLOT_FIELD_W'(home);
         end else begin
            has_head = chain_head(home, head);
            tail = home;
            if (has_head) begin
               tail = head;
               for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
                  if (!linked[tail] || link[tail] >= TABLE_SLOTS) break;
                  tail = link[tail];
               end
            end
            has_free = 1'b0;
            spot = 0;
            for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
               spot = (tail + i) % TABLE_SLOTS;
               if (!held[spot]) begin
                  has_free = 1'b1;
                  break;
               end
            end
            if (has_free) begin
               fill_slot(spot, key);
               if (has_head) begin
                  link[tail] = spot;
                  linked[tail] = 1'b1;
               end
               answer.status = ST_INSERTED;
               answer.slot = SLOT_FIELD_W'(spot);
            end
         end
      end else if (chain_head(home, head)) begin
         cur = head;
         for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
            if (held[cur] && held_key[cur] == key) begin
               answer.status = ST_FOUND;
               answer.slot = SLOT_FIELD_W'(cur);
               break;
            end
            if (!linked[cur] || link[cur] >= TABLE_SLOTS) break;
            cur = link[cur];
         end
      end
      return answer;
   endfunction

   always @(posedge clock) begin
      answer_type oldest;
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            held[i] = 1'b0;
            linked[i] = 1'b0;
         end
         pending_answers.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               mismatches++;
               $display("%0t: response beat with nothing expected, status %0d slot %0d",
                        $time, rsp_status, rsp_slot);
            end else begin
               oldest = pending_answers.pop_front();
               if (rsp_status !== oldest.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, oldest.status, rsp_status);
               end
               if (rsp_slot !== oldest.slot) begin
                  mismatches++;
                  $display("%0t: slot expected %0d actual %0d",
                           $time, oldest.slot, rsp_slot);
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_answers.push_back(hash_answer(req_command, req_key_value));
         end
         outstanding <= pending_answers.size();
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cht_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_command = CMD_INSERT;
   logic [KEY_W-1:0]        req_key_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_status;
   logic [SLOT_FIELD_W-1:0] rsp_slot;

   int outstanding;
   int mismatches;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int insert_pct = 10;
   int phase_send [4] = '{0, 54, 0, 22};
   int phase_stall [4] = '{0, 0, 54, 22};
   logic [KEY_W-1:0] sent_keys [$];

   coalesced_hash_table dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_key_value (req_key_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot)
   );

   cht_checker watch (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_key_value (req_key_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .outstanding   (outstanding),
      .mismatches    (mismatches)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_beat(input logic cmd, input logic [KEY_W-1:0] key);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key_value <= key;
      if (cmd == CMD_INSERT) sent_keys.push_back(key);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Most keys reuse an earlier key or its home so that searches walk real chains.
   task automatic random_beat;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] old;
      logic             cmd;
      key = KEY_W'($urandom());
      if (sent_keys.size() != 0) begin
         old = sent_keys[$urandom_range(sent_keys.size() - 1)];
         case ($urandom_range(7))
            0, 1, 2, 3: key = old;
            4, 5: key = KEY_W'(key - (key % TABLE_SLOTS) + (old % TABLE_SLOTS));
            6: key = KEY_W'($urandom_range(4 * TABLE_SLOTS - 1));
            default: ;
         endcase
      end
      cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_SEARCH;
      send_beat(cmd, key);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(CMD_SEARCH, 31'd0);
      send_beat(CMD_INSERT, 31'd0);
      send_beat(CMD_INSERT, 31'h7FFF_FFFF);
      send_beat(CMD_INSERT, 31'd16);
      send_beat(CMD_INSERT, 31'd1);
      send_beat(CMD_INSERT, 31'd17);
      send_beat(CMD_INSERT, 31'd0);
      send_beat(CMD_SEARCH, 31'd0);
      send_beat(CMD_SEARCH, 31'd16);
      send_beat(CMD_SEARCH, 31'd17);
      send_beat(CMD_SEARCH, 31'd1);
      send_beat(CMD_SEARCH, 31'd32);
      send_beat(CMD_SEARCH, 31'd5);
      send_beat(CMD_SEARCH, 31'h7FFF_FFFF);
      send_beat(CMD_INSERT, 31'h7FFF_FFEF);
      send_beat(CMD_SEARCH, 31'h7FFF_FFEF);
      send_beat(CMD_SEARCH, 31'h5555_5550);
      send_beat(CMD_SEARCH, 31'h2AAA_AAAF);
      drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = phase_send[p];
         stall_pct = phase_stall[p];
         repeat (450) random_beat();
         drain();
      end

      stall_pct = 0;
      repeat (4 * TABLE_SLOTS + 20) @(posedge clock);
      if (mismatches == 0) begin
         $display("coalesced_hash_table verification clean");
      end else begin
         $display("coalesced_hash_table verification failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("coalesced_hash_table verification failed");
      $finish;
   end

endmodule

`default_nettype wire
